[rtl/angular_probe_uv_mapper_top_defines.svh]
// Assertion macros shared by the RTL of the angular probe mapper.
`ifndef ANGULAR_PROBE_UV_MAPPER_TOP_DEFINES_SVH
`define ANGULAR_PROBE_UV_MAPPER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/apm_pkg.sv]
`default_nettype none
package apm_pkg;

	localparam int ANGLE_ITER = 16;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 16;
	localparam int LANE_LAT   = 4 + SQRT_STEPS + ANGLE_ITER + 2 + DIV_STEPS + 1;

	localparam logic signed [32:0] ANG_HALF = 33'sd536870912;
	localparam logic signed [32:0] ANG_FULL = 33'sd1073741824;
	localparam logic [16:0]        UV_MID   = 17'd32768;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [29:0] ax;
		logic [29:0] ay;
		logic [29:0] az;
		logic [30:0] h;
		logic        x_neg;
		logic        y_neg;
		logic        z_neg;
		logic        deg;
	} side_t;

	// atan(2^-i)/pi in Q30
	function automatic logic [28:0] atan_entry(input logic [4:0] idx);
		logic [28:0] r;
		case (idx)
			5'd0:  r = 29'd268435456;
			5'd1:  r = 29'd158466703;
			5'd2:  r = 29'd83729454;
			5'd3:  r = 29'd42502378;
			5'd4:  r = 29'd21333665;
			5'd5:  r = 29'd10677233;
			5'd6:  r = 29'd5339919;
			5'd7:  r = 29'd2670123;
			5'd8:  r = 29'd1335082;
			5'd9:  r = 29'd667543;
			5'd10: r = 29'd333772;
			5'd11: r = 29'd166886;
			5'd12: r = 29'd83443;
			5'd13: r = 29'd41722;
			5'd14: r = 29'd20861;
			5'd15: r = 29'd10430;
			5'd16: r = 29'd5215;
			5'd17: r = 29'd2608;
			5'd18: r = 29'd1304;
			5'd19: r = 29'd652;
			5'd20: r = 29'd326;
			5'd21: r = 29'd163;
			5'd22: r = 29'd81;
			5'd23: r = 29'd41;
			5'd24: r = 29'd20;
			5'd25: r = 29'd10;
			5'd26: r = 29'd5;
			5'd27: r = 29'd3;
			5'd28: r = 29'd1;
			5'd29: r = 29'd1;
			default: r = 29'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/apm_sqrt_cell.sv]
`default_nettype none
module apm_sqrt_cell import apm_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] rad_in,
	input  logic [32:0] rem_in,
	input  logic [30:0] root_in,
	input  side_t       side_in,
	output logic [61:0] rad_out,
	output logic [32:0] rem_out,
	output logic [30:0] root_out,
	output side_t       side_out
);

	logic [34:0] rem_w;
	logic [34:0] trial;
	logic        fits;

	// one root bit per cell: bring down two radicand bits, try 4*root+1
	always_comb begin
		rem_w = {rem_in, rad_in[61:60]};
		trial = {2'b00, root_in, 2'b01};
		fits  = (rem_w >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out  <= {rad_in[59:0], 2'b00};
			rem_out  <= fits ? 33'(rem_w - trial) : rem_w[32:0];
			root_out <= {root_in[29:0], fits};
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

[rtl/apm_cordic_cell.sv]
`default_nettype none
module apm_cordic_cell import apm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [4:0]         idx,
	input  logic signed [33:0] cx_in,
	input  logic signed [33:0] cy_in,
	input  logic signed [32:0] ang_in,
	input  side_t              side_in,
	output logic signed [33:0] cx_out,
	output logic signed [33:0] cy_out,
	output logic signed [32:0] ang_out,
	output side_t              side_out
);

	logic signed [33:0] sx;
	logic signed [33:0] sy;
	logic signed [32:0] da;

	always_comb begin
		sx = cx_in >>> idx;
		sy = cy_in >>> idx;
		da = signed'({4'b0000, atan_entry(idx)});
	end

	// rotate toward the x axis, accumulate the angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (!cy_in[33]) begin
				cx_out  <= cx_in + sy;
				cy_out  <= cy_in - sx;
				ang_out <= ang_in + da;
			end else begin
				cx_out  <= cx_in - sy;
				cy_out  <= cy_in + sx;
				ang_out <= ang_in - da;
			end
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

[rtl/apm_div_cell.sv]
`default_nettype none
module apm_div_cell import apm_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  idx,
	input  logic [45:0] rem_u_in,
	input  logic [45:0] rem_v_in,
	input  logic [15:0] q_u_in,
	input  logic [15:0] q_v_in,
	input  side_t       side_in,
	output logic [45:0] rem_u_out,
	output logic [45:0] rem_v_out,
	output logic [15:0] q_u_out,
	output logic [15:0] q_v_out,
	output side_t       side_out
);

	logic [45:0] trial;
	logic        take_u;
	logic        take_v;

	// one quotient bit per cell for both coordinates, divisor h
	always_comb begin
		trial  = 46'(side_in.h) << idx;
		take_u = (rem_u_in >= trial);
		take_v = (rem_v_in >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_u_out <= take_u ? rem_u_in - trial : rem_u_in;
			rem_v_out <= take_v ? rem_v_in - trial : rem_v_in;
			q_u_out   <= {q_u_in[14:0], take_u};
			q_v_out   <= {q_v_in[14:0], take_v};
			side_out  <= side_in;
		end
	end

endmodule
`default_nettype wire

[rtl/apm_lane.sv]
`default_nettype none
module apm_lane import apm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] d0_x,
	input  logic signed [32:0] d0_y,
	input  logic signed [32:0] d0_z,
	input  logic signed [31:0] step_x,
	input  logic signed [31:0] step_y,
	input  logic signed [31:0] step_z,
	output logic [16:0]        u,
	output logic [16:0]        v,
	output logic               deg
);

	// stage 1: full direction
	logic signed [33:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {d0_x[32], d0_x} + {{2{step_x[31]}}, step_x};
			dy_s1 <= {d0_y[32], d0_y} + {{2{step_y[31]}}, step_y};
			dz_s1 <= {d0_z[32], d0_z} + {{2{step_z[31]}}, step_z};
		end
	end

	// stage 2: magnitudes scaled below 2^30
	logic [33:0] mag_x, mag_y, mag_z, mag_max;
	logic [2:0]  shamt;
	side_t       side_n;
	side_t       side_s2;

	always_comb begin
		mag_x   = dx_s1[33] ? 34'(-dx_s1) : 34'(dx_s1);
		mag_y   = dy_s1[33] ? 34'(-dy_s1) : 34'(dy_s1);
		mag_z   = dz_s1[33] ? 34'(-dz_s1) : 34'(dz_s1);
		mag_max = mag_x;
		if (mag_y > mag_max) mag_max = mag_y;
		if (mag_z > mag_max) mag_max = mag_z;
		if (mag_max[33])      shamt = 3'd4;
		else if (mag_max[32]) shamt = 3'd3;
		else if (mag_max[31]) shamt = 3'd2;
		else if (mag_max[30]) shamt = 3'd1;
		else                  shamt = 3'd0;
		side_n.ax    = 30'(mag_x >> shamt);
		side_n.ay    = 30'(mag_y >> shamt);
		side_n.az    = 30'(mag_z >> shamt);
		side_n.h     = '0;
		side_n.x_neg = dx_s1[33];
		side_n.y_neg = dy_s1[33];
		side_n.z_neg = dz_s1[33];
		side_n.deg   = (side_n.ax == '0) && (side_n.az == '0);
	end

	always_ff @(posedge clk) begin
		if (en) side_s2 <= side_n;
	end

	// stage 3: squares, stage 4: radicand
	logic [59:0] sqx_s3, sqz_s3;
	side_t       side_s3, side_s4;
	logic [61:0] rad_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= side_s2.ax * side_s2.ax;
			sqz_s3  <= side_s2.az * side_s2.az;
			side_s3 <= side_s2;
			rad_s4  <= 62'(sqx_s3) + 62'(sqz_s3);
			side_s4 <= side_s3;
		end
	end

	// square root cells
	logic [61:0] sq_rad  [SQRT_STEPS+1];
	logic [32:0] sq_rem  [SQRT_STEPS+1];
	logic [30:0] sq_root [SQRT_STEPS+1];
	side_t       sq_side [SQRT_STEPS+1];

	assign sq_rad[0]  = rad_s4;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s4;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		apm_sqrt_cell u_cell (
			.clk      (clk),
			.en       (en),
			.rad_in   (sq_rad[g]),
			.rem_in   (sq_rem[g]),
			.root_in  (sq_root[g]),
			.side_in  (sq_side[g]),
			.rad_out  (sq_rad[g+1]),
			.rem_out  (sq_rem[g+1]),
			.root_out (sq_root[g+1]),
			.side_out (sq_side[g+1])
		);
	end

	// angle cells: start from (y, h), or (h, -y) with a quarter turn for y below zero
	logic signed [33:0] co_cx  [ANGLE_ITER+1];
	logic signed [33:0] co_cy  [ANGLE_ITER+1];
	logic signed [32:0] co_ang [ANGLE_ITER+1];
	side_t              co_side[ANGLE_ITER+1];

	always_comb begin
		co_side[0]   = sq_side[SQRT_STEPS];
		co_side[0].h = sq_root[SQRT_STEPS];
		if (co_side[0].y_neg) begin
			co_cx[0]  = signed'({3'b000, sq_root[SQRT_STEPS]});
			co_cy[0]  = signed'({4'b0000, co_side[0].ay});
			co_ang[0] = ANG_HALF;
		end else begin
			co_cx[0]  = signed'({4'b0000, co_side[0].ay});
			co_cy[0]  = signed'({3'b000, sq_root[SQRT_STEPS]});
			co_ang[0] = '0;
		end
	end

	for (genvar g = 0; g < ANGLE_ITER; g++) begin : g_cordic
		apm_cordic_cell u_cell (
			.clk      (clk),
			.en       (en),
			.idx      (5'(g)),
			.cx_in    (co_cx[g]),
			.cy_in    (co_cy[g]),
			.ang_in   (co_ang[g]),
			.side_in  (co_side[g]),
			.cx_out   (co_cx[g+1]),
			.cy_out   (co_cy[g+1]),
			.ang_out  (co_ang[g+1]),
			.side_out (co_side[g+1])
		);
	end

	// clamp angle, scale by the horizontal components, then form the dividends
	logic signed [32:0] ang_end;
	logic [30:0]        t_c;
	logic [60:0]        pu_s5, pv_s5;
	side_t              side_s5, side_s6;
	logic [45:0]        nu_s6, nv_s6;
	logic [61:0]        bias;

	always_comb begin
		ang_end = co_ang[ANGLE_ITER];
		if (ang_end[32])           t_c = '0;
		else if (ang_end > ANG_FULL) t_c = 31'(ANG_FULL);
		else                       t_c = ang_end[30:0];
		bias = 62'(side_s5.h) << 15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s5   <= 61'(co_side[ANGLE_ITER].ax) * 61'(t_c);
			pv_s5   <= 61'(co_side[ANGLE_ITER].az) * 61'(t_c);
			side_s5 <= co_side[ANGLE_ITER];
			nu_s6   <= 46'(({pu_s5, 1'b0} + bias) >> 16);
			nv_s6   <= 46'(({pv_s5, 1'b0} + bias) >> 16);
			side_s6 <= side_s5;
		end
	end

	// divide cells
	logic [45:0] dv_rem_u [DIV_STEPS+1];
	logic [45:0] dv_rem_v [DIV_STEPS+1];
	logic [15:0] dv_q_u   [DIV_STEPS+1];
	logic [15:0] dv_q_v   [DIV_STEPS+1];
	side_t       dv_side  [DIV_STEPS+1];

	assign dv_rem_u[0] = nu_s6;
	assign dv_rem_v[0] = nv_s6;
	assign dv_q_u[0]   = '0;
	assign dv_q_v[0]   = '0;
	assign dv_side[0]  = side_s6;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		apm_div_cell u_cell (
			.clk       (clk),
			.en        (en),
			.idx       (4'(DIV_STEPS - 1 - g)),
			.rem_u_in  (dv_rem_u[g]),
			.rem_v_in  (dv_rem_v[g]),
			.q_u_in    (dv_q_u[g]),
			.q_v_in    (dv_q_v[g]),
			.side_in   (dv_side[g]),
			.rem_u_out (dv_rem_u[g+1]),
			.rem_v_out (dv_rem_v[g+1]),
			.q_u_out   (dv_q_u[g+1]),
			.q_v_out   (dv_q_v[g+1]),
			.side_out  (dv_side[g+1])
		);
	end

	// final: center plus signed half term, center alone when degenerate
	side_t       side_end;
	logic [16:0] q_u_end, q_v_end;

	always_comb begin
		side_end = dv_side[DIV_STEPS];
		q_u_end  = 17'(dv_q_u[DIV_STEPS]);
		q_v_end  = 17'(dv_q_v[DIV_STEPS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_end.deg) begin
				u <= UV_MID;
				v <= UV_MID;
			end else begin
				u <= side_end.x_neg ? UV_MID - q_u_end : UV_MID + q_u_end;
				v <= side_end.z_neg ? UV_MID - q_v_end : UV_MID + q_v_end;
			end
			deg <= side_end.deg;
		end
	end

endmodule
`default_nettype wire

[rtl/angular_probe_uv_mapper_top.sv]
// Angular light-probe mapper: each item (hit point and two screen-step offsets,
// Q16.16) is turned into three directions from the configured probe center, each
// mapped to angular-map u,v in Q1.16; the base u,v and the two differences leave
// in one result item, degenerate in tuser when any direction had no horizontal
// part. One item per cycle is taken while the skid stage is empty, and one result
// per cycle delivered while m_tready is high. Each of three identical lanes is a
// chain of cells: 31 square-root cells, ANGLE_ITER angle-rotation cells and 16
// divide cells. An output register with a skid stage keeps input and output
// apart; the whole pipeline holds only while the skid stage is full. Write
// center registers only while no item is in flight.
`default_nettype none
`include "angular_probe_uv_mapper_top_defines.svh"
module angular_probe_uv_mapper_top import apm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, step_i_x, step_i_y, step_i_z, step_j_x, step_j_y,
	// step_j_z
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// map_u, map_v, du_step_i, dv_step_i, du_step_j, dv_step_j, 6 zero bits
	output logic [111:0] m_tdata,
	// degenerate
	output logic         m_tuser
);

	typedef struct packed {
		logic [17:0] dv_step_j;
		logic [17:0] du_step_j;
		logic [17:0] dv_step_i;
		logic [17:0] du_step_i;
		logic [16:0] map_v;
		logic [16:0] map_u;
		logic        degenerate;
	} out_item_t;

	logic signed [31:0] center_x_q, center_y_q, center_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_CENTER_Z: center_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_vld_q, skid_vld_q;
	logic [LANE_LAT:0] vld_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LANE_LAT-1:0], s_tvalid};
	end

	// stage 1: base direction and offsets
	logic signed [32:0] d0x_s1, d0y_s1, d0z_s1;
	logic signed [31:0] six_s1, siy_s1, siz_s1, sjx_s1, sjy_s1, sjz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d0x_s1 <= {s_tdata[31], s_tdata[31:0]}   - {center_x_q[31], center_x_q};
			d0y_s1 <= {s_tdata[63], s_tdata[63:32]}  - {center_y_q[31], center_y_q};
			d0z_s1 <= {s_tdata[95], s_tdata[95:64]}  - {center_z_q[31], center_z_q};
			six_s1 <= s_tdata[127:96];
			siy_s1 <= s_tdata[159:128];
			siz_s1 <= s_tdata[191:160];
			sjx_s1 <= s_tdata[223:192];
			sjy_s1 <= s_tdata[255:224];
			sjz_s1 <= s_tdata[287:256];
		end
	end

	logic [16:0] u0, v0, ui, vi, uj, vj;
	logic        deg0, degi, degj;

	apm_lane u_lane_base (
		.clk (clk), .en (en),
		.d0_x (d0x_s1), .d0_y (d0y_s1), .d0_z (d0z_s1),
		.step_x ('0), .step_y ('0), .step_z ('0),
		.u (u0), .v (v0), .deg (deg0)
	);

	apm_lane u_lane_i (
		.clk (clk), .en (en),
		.d0_x (d0x_s1), .d0_y (d0y_s1), .d0_z (d0z_s1),
		.step_x (six_s1), .step_y (siy_s1), .step_z (siz_s1),
		.u (ui), .v (vi), .deg (degi)
	);

	apm_lane u_lane_j (
		.clk (clk), .en (en),
		.d0_x (d0x_s1), .d0_y (d0y_s1), .d0_z (d0z_s1),
		.step_x (sjx_s1), .step_y (sjy_s1), .step_z (sjz_s1),
		.u (uj), .v (vj), .deg (degj)
	);

	out_item_t item, out_q, skid_q;
	logic      tail_vld;

	always_comb begin
		tail_vld        = vld_q[LANE_LAT];
		item.map_u      = u0;
		item.map_v      = v0;
		item.du_step_i  = 18'(ui) - 18'(u0);
		item.dv_step_i  = 18'(vi) - 18'(v0);
		item.du_step_j  = 18'(uj) - 18'(u0);
		item.dv_step_j  = 18'(vj) - 18'(v0);
		item.degenerate = deg0 | degi | degj;
	end

	// output register with skid: drain skid first, else take the pipeline tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) skid_vld_q <= 1'b0;
		end else if (tail_vld) begin
			if (!out_vld_q || m_tready) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) out_q <= skid_q;
		end else if (tail_vld) begin
			if (!out_vld_q || m_tready) out_q <= item;
			else skid_q <= item;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b000000, out_q.dv_step_j, out_q.du_step_j, out_q.dv_step_i,
		out_q.du_step_i, out_q.map_v, out_q.map_u};
	assign m_tuser  = out_q.degenerate;

	`APM_ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_vld_q, out_vld_q, "skid full with empty output")
	`APM_ASSERT_NXT(a_stall_fills_skid, clk, arst_n, en && tail_vld && out_vld_q && !m_tready, skid_vld_q, "stalled item not parked in skid")
	`APM_ASSERT_IMP(a_uv_range, clk, arst_n, out_vld_q, (out_q.map_u <= 17'd65536) && (out_q.map_v <= 17'd65536), "base uv out of range")

endmodule
`default_nettype wire

[tb/angular_probe_uv_mapper_top_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module angular_probe_uv_mapper_top_tb;
	import apm_pkg::*;

	localparam int LATENCY   = 56 + ANGLE_ITER;
	localparam int MAX_CYCLE = 400000;

	// highest field first so that {m_tdata[105:0], m_tuser} unpacks directly
	typedef struct packed {
		logic [17:0] dv_j;
		logic [17:0] du_j;
		logic [17:0] dv_i;
		logic [17:0] du_i;
		logic [16:0] map_v;
		logic [16:0] map_u;
		logic        degenerate;
	} uv_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic         m_tuser;

	angular_probe_uv_mapper_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	longint     center_x, center_y, center_z;
	uv_result_t pending_uv[$];
	int         send_idle_pct, recv_idle_pct;
	int         hold_off_cycles;
	int         error_count;
	longint     cycle_count;

	localparam logic [63:0] ATAN_Q30 [32] = '{
		268435456, 158466703, 83729454, 42502378, 21333665, 10677233, 5339919,
		2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
		5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint floor_sh(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint coord_term(longint a, bit neg, longint t, longint h);
		longint unsigned num, den, q;
		num = a * t;
		den = h << 15;
		q = (2 * num + den) / (2 * den);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// map one direction to u,v; returns 1 when it has no horizontal part
	function automatic bit map_direction(longint x, longint y, longint z,
			output longint u, output longint v);
		longint ax, ay, az, m, h, cx, cy, ang, nx, ny;
		int s;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		s = 0;
		while ((m >> s) >= (64'd1 << 30)) s++;
		ax >>= s;
		ay >>= s;
		az >>= s;
		if (ax == 0 && az == 0) begin
			u = 32768;
			v = 32768;
			return 1'b1;
		end
		h = int_sqrt(ax * ax + az * az);
		if (y >= 0) begin
			cx = ay; cy = h; ang = 0;
		end else begin
			cx = h; cy = ay; ang = 64'd1 << 29;
		end
		for (int i = 0; i < ANGLE_ITER && i < 32; i++) begin
			if (cy >= 0) begin
				nx = cx + floor_sh(cy, i);
				ny = cy - floor_sh(cx, i);
				ang += ATAN_Q30[i];
			end else begin
				nx = cx - floor_sh(cy, i);
				ny = cy + floor_sh(cx, i);
				ang -= ATAN_Q30[i];
			end
			cx = nx;
			cy = ny;
		end
		if (ang < 0) ang = 0;
		if (ang > (64'd1 << 30)) ang = 64'd1 << 30;
		u = 32768 + coord_term(ax, x < 0, ang, h);
		v = 32768 + coord_term(az, z < 0, ang, h);
		return 1'b0;
	endfunction

	function automatic uv_result_t predict_uv(logic [287:0] d);
		longint p[9];
		longint x0, y0, z0, u0, v0, ui, vi, uj, vj;
		bit deg;
		uv_result_t r;
		for (int k = 0; k < 9; k++) p[k] = longint'($signed(d[32*k +: 32]));
		x0 = p[0] - center_x;
		y0 = p[1] - center_y;
		z0 = p[2] - center_z;
		deg = map_direction(x0, y0, z0, u0, v0);
		deg |= map_direction(x0 + p[3], y0 + p[4], z0 + p[5], ui, vi);
		deg |= map_direction(x0 + p[6], y0 + p[7], z0 + p[8], uj, vj);
		r.map_u = u0[16:0];
		r.map_v = v0[16:0];
		r.du_i = 18'(ui - u0);
		r.dv_i = 18'(vi - v0);
		r.du_j = 18'(uj - u0);
		r.dv_j = 18'(vj - v0);
		r.degenerate = deg;
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		uv_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[105:0], m_tuser};
			if (pending_uv.size() == 0) begin
				$error("result item with no expectation waiting");
				error_count++;
			end else begin
				want = pending_uv.pop_front();
				if (got.map_u !== want.map_u) begin
					$error("map_u exp %0d got %0d", want.map_u, got.map_u); error_count++;
				end
				if (got.map_v !== want.map_v) begin
					$error("map_v exp %0d got %0d", want.map_v, got.map_v); error_count++;
				end
				if (got.du_i !== want.du_i) begin
					$error("du_step_i exp %0d got %0d", $signed(want.du_i),
						$signed(got.du_i)); error_count++;
				end
				if (got.dv_i !== want.dv_i) begin
					$error("dv_step_i exp %0d got %0d", $signed(want.dv_i),
						$signed(got.dv_i)); error_count++;
				end
				if (got.du_j !== want.du_j) begin
					$error("du_step_j exp %0d got %0d", $signed(want.du_j),
						$signed(got.du_j)); error_count++;
				end
				if (got.dv_j !== want.dv_j) begin
					$error("dv_step_j exp %0d got %0d", $signed(want.dv_j),
						$signed(got.dv_j)); error_count++;
				end
				if (got.degenerate !== want.degenerate) begin
					$error("degenerate exp %0b got %0b", want.degenerate,
						got.degenerate); error_count++;
				end
			end
		end
	end

	// leave tvalid as it is after the accepting edge; the next caller drops it
	task automatic send_item(logic [287:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_uv.push_back(predict_uv(d));
	endtask

	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_uv.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_center(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_X: center_x = longint'($signed(val));
			REG_CENTER_Y: center_y = longint'($signed(val));
			default:      center_z = longint'($signed(val));
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2047)) - 1024) <<< 16;
			2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			3: return 32'($signed($urandom_range(63)) - 32);
			default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
		endcase
	endfunction

	function automatic logic [287:0] rand_item();
		logic [287:0] d;
		for (int k = 0; k < 3; k++) d[32*k +: 32] = rand_coord();
		for (int k = 3; k < 9; k++)
			d[32*k +: 32] = ($urandom_range(3) == 0) ? rand_coord()
				: 32'($signed($urandom_range(4095)) - 2048);
		// sometimes make step i cancel the horizontal part of the point
		if ($urandom_range(15) == 0) begin
			d[32*3 +: 32] = -d[31:0];
			d[32*5 +: 32] = -d[95:64];
		end
		return d;
	endfunction

	task automatic test_directed();
		logic [31:0] ext[6];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h0001_0000};
		send_item('0);
		send_item({192'd0, 32'd0, 32'h0001_0000, 32'd0});
		send_item({192'd0, 32'd0, 32'hffff_0000, 32'd0});
		send_item({32'd0, 32'd0, 32'h0001_0000, 96'd0, 32'd0, 32'd0, 32'h0001_0000});
		send_item({288{1'b1}});
		send_item({9{32'h8000_0000}});
		send_item({9{32'h7fff_ffff}});
		send_item({{3{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}}});
		send_item({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		for (int k = 0; k < 12; k++)
			send_item({ext[$urandom_range(5)], ext[$urandom_range(5)], ext[$urandom_range(5)],
				ext[$urandom_range(5)], ext[$urandom_range(5)], ext[$urandom_range(5)],
				ext[$urandom_range(5)], ext[$urandom_range(5)], ext[$urandom_range(5)]});
		send_item({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'h7000_0000, 32'h1});
		drain_pipeline();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) send_item(rand_item());
	endtask

	task automatic test_centers();
		write_center(REG_CENTER_X, 32'h8000_0000);
		write_center(REG_CENTER_Y, 32'h7fff_ffff);
		write_center(REG_CENTER_Z, 32'h8000_0000);
		send_item('0);
		test_random(30);
		drain_pipeline();
		write_center(REG_CENTER_X, 32'h7fff_ffff);
		write_center(REG_CENTER_Y, 32'h8000_0000);
		write_center(REG_CENTER_Z, 32'h7fff_ffff);
		test_random(30);
		drain_pipeline();
		write_center(REG_CENTER_X, rand_coord());
		write_center(REG_CENTER_Y, rand_coord());
		write_center(REG_CENTER_Z, rand_coord());
		test_random(40);
		drain_pipeline();
		write_center(REG_CENTER_X, 32'h0);
		write_center(REG_CENTER_Y, 32'h0);
		write_center(REG_CENTER_Z, 32'h0);
	endtask

	task automatic test_backpressure();
		hold_off_cycles <= 3 * LATENCY;
		send_idle_pct = 0;
		test_random(LATENCY + 20);
		// pause until every result has come back
		s_tvalid <= 1'b0;
		while (pending_uv.size() != 0) @(posedge clk);
		test_random(10);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_off_cycles = 0;
		error_count = 0;
		cycle_count = 0;
		center_x = 0;
		center_y = 0;
		center_z = 0;
		send_idle_pct = 28;
		recv_idle_pct = 60;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_centers();
		send_idle_pct = 60;
		recv_idle_pct = 28;
		test_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(60);
		test_backpressure();
		send_idle_pct = 28;
		recv_idle_pct = 60;
		test_random(30);

		drain_pipeline();
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
